// ----- sv/mtld_pkg.sv -----
// ----------------------------------------------------------------------------
// mtld_pkg
// Shared types and constants for the magic/type/length deframer.
// ----------------------------------------------------------------------------
package mtld_pkg;

  localparam int unsigned MAGIC_LEN = 4;

  // Header is magic (4) + type (1) + length (4); code 9 marks the body phase
  localparam logic [3:0] HDR_LAST   = 4'd8;
  localparam logic [3:0] TYPE_POS   = 4'd4;
  localparam logic [3:0] BODY_PHASE = 4'd9;

  typedef enum logic [1:0] {
    KIND_BODY      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BAD_MAGIC = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] pkt_type;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic halted;
    logic in_body;
  } parse_status_t;

  // Expected magic bytes: 'J', 'I', 'I', 'T'
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h4A;
      2'd1:    val = 8'h49;
      2'd2:    val = 8'h49;
      default: val = 8'h54;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/magic_type_length_deframer.sv -----
// ----------------------------------------------------------------------------
// magic_type_length_deframer
// Byte-serial deframer for a magic/type/length packet stream.
// ----------------------------------------------------------------------------
// Path: a request accepted into the input register moves into the result
//   register once that register is free or draining, and is taken from the
//   result register by the consumer.
// Throughput: one byte per cycle when the output is not stalled; the parser
//   step is a single pass of compare and counter update between the registers.
// Reset (rst, synchronous): clears header position, length, type and the halt
//   flag, and empties both registers. Nothing needs sweeping after reset.
// ----------------------------------------------------------------------------
module magic_type_length_deframer
  import mtld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] pkt_type,
  output logic [7:0] data_byte,
  output logic       last
);

  logic          held_valid;
  logic [7:0]    held_byte;
  logic          advance;
  logic          res_valid;
  result_t       res;
  result_t       out_res;
  parse_status_t status;

  // The held byte moves on when the result register is free or draining now.
  // Bytes that give no result still step the parser.
  assign advance = held_valid && (!out_valid || out_ready);

  mtld_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mtld_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (held_byte),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  mtld_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_res  (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind      = out_res.kind;
  assign pkt_type  = out_res.pkt_type;
  assign data_byte = out_res.data_byte;
  assign last      = out_res.last;

  // Once halted, the parser must not produce any further result
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    status.halted |-> !res_valid)
    else $error("result produced while halted");

  // A bad-magic result must leave the parser halted
  a_bad_halts: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid && res.kind == KIND_BAD_MAGIC) |=> status.halted)
    else $error("bad magic did not halt the parser");

  // Body results only come out of the body phase
  a_body_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_BODY) |-> status.in_body)
    else $error("body result outside body phase");

  // The result register is never overwritten while it holds an untaken request
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !advance)
    else $error("result register overrun");

endmodule

// ----- sv/mtld_in_reg.sv -----
// ----------------------------------------------------------------------------
// mtld_in_reg
// Input register: holds one received byte until the parser steps on it.
// ----------------------------------------------------------------------------
module mtld_in_reg
  import mtld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ----- sv/mtld_parser.sv -----
// ----------------------------------------------------------------------------
// mtld_parser
// Header/body state and the per-byte decode; one byte per step.
// ----------------------------------------------------------------------------
module mtld_parser
  import mtld_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    in_byte,
  output logic          res_valid,
  output result_t       res,
  output parse_status_t status
);

  logic [3:0]  header_position, header_position_next;
  logic        magic_match, magic_match_next;
  logic [7:0]  held_type, held_type_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic        halted, halted_next;

  always_comb begin
    header_position_next = header_position;
    magic_match_next     = magic_match;
    held_type_next       = held_type;
    bytes_remaining_next = bytes_remaining;
    halted_next          = halted;
    res_valid            = 1'b0;
    res                  = '{kind: KIND_BODY, pkt_type: 8'd0, data_byte: 8'd0, last: 1'b0};

    if (!halted) begin
      if (header_position <= HDR_LAST) begin
        if (header_position < TYPE_POS) begin
          if (in_byte != magic_byte(header_position[1:0])) begin
            magic_match_next = 1'b0;
          end
        end else if (header_position == TYPE_POS) begin
          held_type_next = in_byte;
        end else begin
          bytes_remaining_next = {bytes_remaining[23:0], in_byte};
        end

        if (header_position != HDR_LAST) begin
          header_position_next = header_position + 4'd1;
        end else if (!magic_match_next) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res.kind    = KIND_BAD_MAGIC;
        end else if (bytes_remaining_next == 32'd0) begin
          res_valid            = 1'b1;
          res.kind             = KIND_EMPTY;
          res.pkt_type         = held_type_next;
          res.last             = 1'b1;
          header_position_next = 4'd0;
          magic_match_next     = 1'b1;
        end else begin
          header_position_next = BODY_PHASE;
        end
      end else begin
        // body phase; codes above nine behave the same
        bytes_remaining_next = bytes_remaining - 32'd1;
        res_valid            = 1'b1;
        res.kind             = KIND_BODY;
        res.pkt_type         = held_type;
        res.data_byte        = in_byte;
        if (bytes_remaining == 32'd1) begin
          res.last             = 1'b1;
          header_position_next = 4'd0;
          magic_match_next     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= 4'd0;
      magic_match     <= 1'b1;
      held_type       <= 8'd0;
      bytes_remaining <= 32'd0;
      halted          <= 1'b0;
    end else if (step) begin
      header_position <= header_position_next;
      magic_match     <= magic_match_next;
      held_type       <= held_type_next;
      bytes_remaining <= bytes_remaining_next;
      halted          <= halted_next;
    end
  end

  assign status.halted  = halted;
  assign status.in_body = (header_position > HDR_LAST);

endmodule

// ----- sv/mtld_out_reg.sv -----
// ----------------------------------------------------------------------------
// mtld_out_reg
// Result register on the output channel.
// ----------------------------------------------------------------------------
module mtld_out_reg
  import mtld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule
